// ===== rtl/core/llt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

  localparam int KEY_W      = 64;
  localparam int DST_W      = 32;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 4;

  localparam logic [LEN_W-1:0] ID_LEN_FULL = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE = 4'd1;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_DEL,
    REQ_LOOKUP
  } req_t;

  typedef enum logic [2:0] {
    STAT_OK,
    STAT_NOENTRY,
    STAT_FULL,
    STAT_NOTFOUND,
    STAT_DROPPED
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_NEXT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    PASS_FIND,
    PASS_ADD,
    PASS_FIX
  } pass_t;

  typedef struct packed {
    logic  load;       // capture the accepted request
    logic  scan_rst;   // return the scan address to slot 0
    logic  scan_step;  // issue one slot read and advance
    logic  clear_wr;   // invalidate the slot at the scan address
    logic  proc;       // act on read data with the current pass
    pass_t pass;
    logic  out_load;   // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_req;   // id_length write with a new value
    logic issue_last;  // scan address is on the last slot
    logic full;
    logic drop;
    logic best_hit;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/llt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llt_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [1:0]           in_req,
  input  llt_pkg::dp_status_t  stat,
  output llt_pkg::ctrl_cmd_t   cmd
);
  import llt_pkg::*;

  state_t      state_r, state_nxt;
  pass_t       pass_r, pass_nxt;
  logic [1:0]  req_r, req_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pass_r  <= PASS_FIND;
      req_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      req_r   <= req_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    req_nxt   = req_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.scan_step = 1'b1;
        cmd.clear_wr  = 1'b1;
        if (stat.issue_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          req_nxt  = in_req;
          case (in_req)
            REQ_ADD: begin
              if (stat.full) begin
                state_nxt = S_RESULT;
              end else begin
                pass_nxt  = PASS_ADD;
                state_nxt = S_SCAN;
              end
            end
            REQ_DEL: begin
              pass_nxt  = PASS_FIND;
              state_nxt = S_SCAN;
            end
            REQ_LOOKUP: begin
              if (stat.drop) begin
                state_nxt = S_RESULT;
              end else begin
                pass_nxt  = PASS_FIND;
                state_nxt = S_SCAN;
              end
            end
            default: ;  // unknown request: drop it
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.proc      = 1'b1;
        if (stat.issue_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.proc  = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (pass_r == PASS_FIND && req_r == REQ_DEL && stat.best_hit) begin
          pass_nxt  = PASS_FIX;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    cmd.pass = pass_r;
    // a new id length restarts the clearing pass
    if (stat.clear_req) begin
      in_tready     = 1'b0;
      cmd.load      = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.clear_wr  = 1'b0;
      cmd.proc      = 1'b0;
      cmd.scan_rst  = 1'b1;
      state_nxt     = S_CLEAR;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/llt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llt_dp #(
  parameter int ENTRIES = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  input  wire  [llt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [llt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [1:0]                         in_req,
  input  wire  [llt_pkg::KEY_W-1:0]          in_id,
  input  wire  [llt_pkg::DST_W-1:0]          in_dst,
  input  wire  [llt_pkg::KEY_W-1:0]          in_word,
  input  llt_pkg::ctrl_cmd_t                 cmd,
  output llt_pkg::dp_status_t                stat,
  input  wire                                out_tready,
  output logic                               out_tvalid,
  output logic [2:0]                         out_status,
  output logic [llt_pkg::DST_W-1:0]          out_dst,
  output logic                               out_used_def,
  output logic [llt_pkg::KEY_W-1:0]          out_pid
);
  import llt_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic             valid;
    logic [AW-1:0]    rank;
    logic [KEY_W-1:0] key;
    logic [DST_W-1:0] dest;
  } slot_t;

  slot_t mem [ENTRIES];

  logic [LEN_W-1:0] id_len_r;
  logic             drop_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    scan_addr_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_idx_r;
  slot_t            rd_slot_r;

  logic [1:0]       req_r;
  logic [KEY_W-1:0] key_r;
  logic [DST_W-1:0] dst_r;
  logic [KEY_W-1:0] pid_r;
  logic             full_r;
  logic             drop_req_r;
  logic             found_r;
  logic             hit_r;
  logic [AW-1:0]    hit_idx_r;
  logic [AW-1:0]    hit_rank_r;
  logic [DST_W-1:0] hit_dst_r;
  logic             def_hit_r;
  logic [AW-1:0]    def_rank_r;
  logic [DST_W-1:0] def_dst_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [DST_W-1:0] out_dst_r;
  logic             out_def_r;
  logic [KEY_W-1:0] out_pid_r;

  logic             clear_req;
  logic [LEN_W-1:0] shamt;
  logic [KEY_W-1:0] pid_comb;
  logic             act;
  logic             add_wr;
  logic             fix_del;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  slot_t            mem_wd;
  logic             id_match;
  logic             def_match;
  status_t          res_status;
  logic [DST_W-1:0] res_dst;
  logic             res_def;
  logic [KEY_W-1:0] res_pid;

  assign clear_req = cfg_valid && cfg_index == CFG_ID_LENGTH && cfg_data != id_len_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_len_r <= '0;
      drop_r   <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ID_LENGTH) id_len_r <= cfg_data;
      if (cfg_index == CFG_DROP_MODE) drop_r   <= cfg_data[0];
    end
  end

  // packet id: top id_length bits of the word
  always_comb begin
    shamt = ID_LEN_FULL - id_len_r;
    if (id_len_r == '0) begin
      pid_comb = '0;
    end else if (id_len_r >= ID_LEN_FULL) begin
      pid_comb = in_word;
    end else begin
      pid_comb = in_word >> shamt[5:0];
    end
  end

  assign act       = cmd.proc && rd_vld_r;
  assign add_wr    = act && cmd.pass == PASS_ADD && !rd_slot_r.valid && !found_r;
  assign fix_del   = act && cmd.pass == PASS_FIX && rd_idx_r == hit_idx_r;
  assign id_match  = rd_slot_r.valid && rd_slot_r.key == key_r;
  assign def_match = rd_slot_r.valid && rd_slot_r.key == '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_idx_r;
    mem_wd = rd_slot_r;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
      mem_wa = scan_addr_r;
      mem_wd = '0;
    end else if (add_wr) begin
      mem_we      = 1'b1;
      mem_wd.valid = 1'b1;
      mem_wd.rank  = cnt_r[AW-1:0];
      mem_wd.key   = key_r;
      mem_wd.dest  = dst_r;
    end else if (fix_del) begin
      mem_we       = 1'b1;
      mem_wd.valid = 1'b0;
    end else if (act && cmd.pass == PASS_FIX && rd_slot_r.valid
                 && rd_slot_r.rank > hit_rank_r) begin
      mem_we      = 1'b1;
      mem_wd.rank = rd_slot_r.rank - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.scan_step) rd_slot_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step && !cmd.clear_wr;
      if (cmd.scan_rst) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_step) begin
        scan_addr_r <= (scan_addr_r == AW'(ENTRIES - 1)) ? '0 : scan_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_addr_r;
  end

  // live entry count
  always_ff @(posedge clk) begin
    if (!rst_n || clear_req) begin
      cnt_r <= '0;
    end else if (add_wr) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (fix_del) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // request capture and scan trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      hit_r     <= 1'b0;
      def_hit_r <= 1'b0;
    end else if (cmd.load) begin
      found_r   <= 1'b0;
      hit_r     <= 1'b0;
      def_hit_r <= 1'b0;
    end else begin
      if (add_wr) found_r <= 1'b1;
      if (act && cmd.pass == PASS_FIND) begin
        if (id_match && (!hit_r || rd_slot_r.rank > hit_rank_r)) hit_r <= 1'b1;
        if (def_match && (!def_hit_r || rd_slot_r.rank > def_rank_r)) def_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r      <= in_req;
      key_r      <= (in_req == REQ_DEL || in_req == REQ_ADD) ? in_id : pid_comb;
      dst_r      <= in_dst;
      pid_r      <= pid_comb;
      full_r     <= stat.full;
      drop_req_r <= drop_r;
    end
    if (act && cmd.pass == PASS_FIND) begin
      if (id_match && (!hit_r || rd_slot_r.rank > hit_rank_r)) begin
        hit_idx_r  <= rd_idx_r;
        hit_rank_r <= rd_slot_r.rank;
        hit_dst_r  <= rd_slot_r.dest;
      end
      if (def_match && (!def_hit_r || rd_slot_r.rank > def_rank_r)) begin
        def_rank_r <= rd_slot_r.rank;
        def_dst_r  <= rd_slot_r.dest;
      end
    end
  end

  // result formation
  always_comb begin
    res_status = STAT_OK;
    res_dst    = '0;
    res_def    = 1'b0;
    res_pid    = '0;
    case (req_r)
      REQ_ADD: res_status = full_r ? STAT_FULL : STAT_OK;
      REQ_DEL: res_status = hit_r ? STAT_OK : STAT_NOTFOUND;
      REQ_LOOKUP: begin
        if (drop_req_r) begin
          res_status = STAT_DROPPED;
        end else begin
          res_pid = pid_r;
          if (hit_r) begin
            res_dst = hit_dst_r;
          end else if (pid_r != '0 && def_hit_r) begin
            res_dst = def_dst_r;
            res_def = 1'b1;
          end else begin
            res_status = STAT_NOENTRY;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status;
      out_dst_r    <= res_dst;
      out_def_r    <= res_def;
      out_pid_r    <= res_pid;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_status   = out_status_r;
  assign out_dst      = out_dst_r;
  assign out_used_def = out_def_r;
  assign out_pid      = out_pid_r;

  always_comb begin
    stat            = '0;
    stat.clear_req  = clear_req;
    stat.issue_last = scan_addr_r == AW'(ENTRIES - 1);
    stat.full       = cnt_r == CW'(ENTRIES);
    stat.drop       = drop_r;
    stat.best_hit   = hit_r;
    stat.out_busy   = out_valid_r && !out_tready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/locator_lookup_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid / in_tready   tdata: entry_id, entry_dst, packet_word; tuser: req_type
// out_     out  out_tvalid / out_tready tdata: dst_addr, packet_id; tuser: status, used_default
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request at a time; every table walk reads one slot per cycle from the slot memory.
// Lookup, add and a delete that misses walk the table once; a delete that finds its id
// walks it twice. Full adds and dropped lookups skip the walk; unknown kinds are dropped.
// Reset and every id_length write with a new value run a clearing pass over all slots
// with in_tready low. A stalled result holds in the output register; the next
// request is taken meanwhile and waits for it only at the end of its own walk.

module locator_lookup_table_core #(
  parameter int ENTRIES = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [63:0] entry_id, [95:64] entry_dst, [159:96] packet_word
  input  wire  [llt_pkg::IN_DATA_W-1:0]       in_tdata,
  // [1:0] req_type
  input  wire  [llt_pkg::IN_USER_W-1:0]       in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [31:0] dst_addr, [95:32] packet_id
  output logic [llt_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [2:0] status, [3] used_default
  output logic [llt_pkg::OUT_USER_W-1:0]      out_tuser,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [llt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [llt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import llt_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       stat;
  logic [2:0]       res_status;
  logic [DST_W-1:0] res_dst;
  logic             res_def;
  logic [KEY_W-1:0] res_pid;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  llt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser[1:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  llt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req       (in_tuser[1:0]),
    .in_id        (in_tdata[63:0]),
    .in_dst       (in_tdata[95:64]),
    .in_word      (in_tdata[159:96]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (res_status),
    .out_dst      (res_dst),
    .out_used_def (res_def),
    .out_pid      (res_pid)
  );

  // pack the result
  assign out_tdata = {res_pid, res_dst};
  assign out_tuser = {res_def, res_status};

endmodule

`default_nettype wire

// ===== rtl/core/llt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module llt_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [llt_pkg::IN_USER_W-1:0]    in_tuser,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [llt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire [llt_pkg::OUT_USER_W-1:0]   out_tuser
);
  import llt_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_tready)
    else $error("request taken during clearing pass");

  // a known request keeps the block busy: in_tready is low in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[1:0] == REQ_ADD || in_tuser[1:0] == REQ_DEL
      || in_tuser[1:0] == REQ_LOOKUP) |=> !in_tready)
    else $error("request taken while previous one in progress");

  // default fallback only on a successful lookup of a nonzero id
  a_default_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == STAT_OK && out_tdata[95:32] != '0)
    else $error("default fallback with bad status or zero id");

endmodule

bind locator_lookup_table_core llt_checker u_llt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_locator_lookup_table_core.sv =====
`timescale 1ns / 1ps

module tb_locator_lookup_table_core;
  import llt_pkg::*;

  localparam int ENTRIES = 64;
  // Slowest walk (delete that hits) plus margin; waited out before register writes and at the end.
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 16;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;
  // Request kind 3 is not in req_t: the block must ignore it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] entry_id;
    logic [31:0] entry_dst;
    logic [63:0] packet_word;
  } locator_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] dst_addr;
    logic        used_default;
    logic [63:0] packet_id;
  } locator_resp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  locator_lookup_table_core #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Locator table shadow: the expected contents of the block's slot memory.
  // ---------------------------------------------------------------------------
  bit          slot_live[ENTRIES];
  logic [63:0] slot_id[ENTRIES];
  logic [31:0] slot_dst[ENTRIES];
  int          slot_age[ENTRIES];   // 0 oldest, live_entries-1 newest
  int          live_entries;
  logic [6:0]  id_len_reg;
  bit          drop_reg;

  // Run statistics for the closing summary.
  int n_adds, n_dels, n_lookups, n_full, n_missed_dels, n_fallbacks, n_empty, n_drops;
  int n_settings;

  locator_req_t  pending_requests[$];
  locator_resp_t expected_responses[$];

  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_requests;
  int holdoff_served;
  int holdoff_left;
  int cycle_count;
  int n_checked;
  int n_errors;

  locator_req_t  in_flight;
  locator_resp_t next_resp;

  logic [63:0] key_pool[6];

  function automatic void flush_slots();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_live[i] = 1'b0;
    end
    live_entries = 0;
  endfunction

  // Index of the newest live slot holding id, or -1.
  function automatic int newest_slot(logic [63:0] id);
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && slot_id[i] == id) begin
        if (best < 0 || slot_age[i] > slot_age[best]) best = i;
      end
    end
    return best;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    if (idx == CFG_ID_LENGTH) begin
      // Only a changed length wipes the table.
      if (val != id_len_reg) begin
        flush_slots();
        id_len_reg = val;
      end
    end else if (idx == CFG_DROP_MODE) begin
      drop_reg = val[0];
    end
  endfunction

  function automatic logic [63:0] packet_locator(logic [63:0] word);
    if (id_len_reg == 7'd0) return 64'd0;
    if (id_len_reg >= ID_LEN_FULL) return word;
    return word >> (7'd64 - id_len_reg);
  endfunction

  // Apply one request to the shadow table; returns 0 when no response is due.
  function automatic bit locator_outcome(locator_req_t req, output locator_resp_t resp);
    int hit;
    int free_slot;
    int gone_age;
    resp.status       = STAT_OK;
    resp.dst_addr     = '0;
    resp.used_default = 1'b0;
    resp.packet_id    = '0;
    case (req.kind)
      REQ_ADD: begin
        n_adds++;
        free_slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_live[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          resp.status = STAT_FULL;
          n_full++;
        end else begin
          slot_live[free_slot] = 1'b1;
          slot_id[free_slot]   = req.entry_id;
          slot_dst[free_slot]  = req.entry_dst;
          slot_age[free_slot]  = live_entries;
          live_entries++;
        end
      end
      REQ_DEL: begin
        n_dels++;
        hit = newest_slot(req.entry_id);
        if (hit < 0) begin
          resp.status = STAT_NOTFOUND;
          n_missed_dels++;
        end else begin
          gone_age = slot_age[hit];
          slot_live[hit] = 1'b0;
          // Close the gap in the age order.
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && slot_age[i] > gone_age) slot_age[i]--;
          end
          live_entries--;
        end
      end
      REQ_LOOKUP: begin
        n_lookups++;
        if (drop_reg) begin
          resp.status = STAT_DROPPED;
          n_drops++;
        end else begin
          resp.packet_id = packet_locator(req.packet_word);
          hit = newest_slot(resp.packet_id);
          // Fall back to the id 0 entry, but never for a packet that already asked for id 0.
          if (hit < 0 && resp.packet_id != 64'd0) begin
            hit = newest_slot(64'd0);
            if (hit >= 0) begin
              resp.used_default = 1'b1;
              n_fallbacks++;
            end
          end
          if (hit < 0) begin
            resp.status = STAT_NOENTRY;
            n_empty++;
          end else begin
            resp.dst_addr = slot_dst[hit];
          end
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: present queued requests, predict each one as it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (locator_outcome(in_flight, next_resp)) expected_responses.push_back(next_resp);
      end
      // Advance only when the slot is free; otherwise hold the request on the bus.
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {in_flight.packet_word, in_flight.entry_dst, in_flight.entry_id};
          in_tuser  <= in_flight.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response sink: random stalls, plus long hold-offs on demand.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_requests != holdoff_served) begin
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_tready     <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Response checker: compare each taken response with the oldest prediction.
  always @(posedge clk) begin
    locator_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (expected_responses.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT)
          $display("[%0t] unexpected response: status=%0d dst=%h default=%b id=%h", $realtime,
                   out_tuser[2:0], out_tdata[31:0], out_tuser[3], out_tdata[95:32]);
      end else begin
        want = expected_responses.pop_front();
        if (out_tuser[2:0] !== want.status || out_tdata[31:0] !== want.dst_addr ||
            out_tuser[3] !== want.used_default || out_tdata[95:32] !== want.packet_id) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: expected status=%0d dst=%h default=%b id=%h", $realtime,
                     want.status, want.dst_addr, want.used_default, want.packet_id);
            $display("               actual   status=%0d dst=%h default=%b id=%h",
                     out_tuser[2:0], out_tdata[31:0], out_tuser[3], out_tdata[95:32]);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               expected_responses.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int eff_len();
    return (id_len_reg >= ID_LEN_FULL) ? 64 : int'(id_len_reg);
  endfunction

  // Ids a lookup can produce at the current length.
  function automatic logic [63:0] id_mask();
    if (eff_len() == 0) return 64'd0;
    if (eff_len() == 64) return '1;
    return (64'd1 << eff_len()) - 64'd1;
  endfunction

  // Place id in the top bits of a packet word, random bits below it.
  function automatic logic [63:0] word_for_id(logic [63:0] id);
    int n;
    n = eff_len();
    if (n == 0) return rand64();
    if (n == 64) return id;
    return (id << (64 - n)) | (rand64() & ((64'd1 << (64 - n)) - 64'd1));
  endfunction

  function automatic void refill_key_pool();
    key_pool[0] = 64'd0;
    key_pool[1] = id_mask();
    for (int i = 2; i < 6; i++) key_pool[i] = rand64() & id_mask();
  endfunction

  function automatic logic [31:0] rand_dst();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [63:0] pick_key();
    // Mostly ids that lookups can reach, now and then any 64-bit id.
    if ($urandom_range(9) == 0) return rand64();
    return key_pool[$urandom_range(5)];
  endfunction

  task automatic queue_req(logic [1:0] kind, logic [63:0] id, logic [31:0] dst,
                           logic [63:0] word);
    locator_req_t r;
    r.kind        = kind;
    r.entry_id    = id;
    r.entry_dst   = dst;
    r.packet_word = word;
    pending_requests.push_back(r);
  endtask

  // Queue n counted requests; ignored kinds are sprinkled in and not counted.
  task automatic queue_random(int n, int add_pct, int del_pct);
    int made;
    int pick;
    logic [63:0] word;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        queue_req(REQ_UNUSED, rand64(), $urandom(), rand64());
      end else begin
        made++;
        if (pick < 3 + add_pct) begin
          queue_req(REQ_ADD, pick_key(), rand_dst(), rand64());
        end else if (pick < 3 + add_pct + del_pct) begin
          queue_req(REQ_DEL, pick_key(), $urandom(), rand64());
        end else begin
          case ($urandom_range(9))
            6:       word = 64'd0;
            7:       word = '1;
            8, 9:    word = rand64();
            default: word = word_for_id(key_pool[$urandom_range(5)]);
          endcase
          queue_req(REQ_LOOKUP, rand64(), $urandom(), word);
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_responses.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    apply_register(idx, val);
    cfg_valid <= 1'b0;
    // Step off this edge so a following write never flips valid twice in one step.
    @(posedge clk);
  endtask

  // Reconfigure while idle, then run one stretch of random traffic with a drain halfway.
  task automatic run_phase(logic [6:0] len, bit drop, int send_pct, int recv_pct, int n,
                           int add_pct, int del_pct, bit long_holdoff);
    logic [6:0] old_len;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    old_len = id_len_reg;
    write_reg(CFG_ID_LENGTH, len);
    write_reg(CFG_DROP_MODE, {6'd0, drop});
    n_settings++;
    if (len != old_len) refill_key_pool();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random(n / 2, add_pct, del_pct);
    // Stop the sink for a long stretch while requests keep coming; the block must back up.
    if (long_holdoff) holdoff_requests++;
    // Pause the sender until every response is back.
    wait_drained();
    queue_random(n - n / 2, add_pct, del_pct);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_requests = 0;
    holdoff_served = 0;
    holdoff_left = 0;
    cycle_count = 0;
    n_checked = 0;
    n_errors = 0;
    id_len_reg = 7'd0;
    drop_reg = 1'b0;
    flush_slots();
    refill_key_pool();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full 64-bit ids, shadowing, default fallback and its limits.
    write_reg(CFG_ID_LENGTH, ID_LEN_FULL);
    write_reg(CFG_DROP_MODE, 7'd0);
    n_settings++;
    refill_key_pool();
    queue_req(REQ_LOOKUP, '1, '1, 64'd0);               // empty table, id 0
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, '1);            // empty table, no default
    queue_req(REQ_DEL, 64'd0, 32'd0, 64'd0);            // nothing to delete
    queue_req(REQ_ADD, 64'd0, '1, '1);                  // default entry
    queue_req(REQ_ADD, '1, 32'd0, 64'd0);
    queue_req(REQ_ADD, '1, 32'h1234_5678, 64'd0);       // shadows the previous one
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, '1);            // newest wins
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, 64'h5555_5555_5555_5555);  // falls back
    queue_req(REQ_DEL, '1, 32'd0, 64'd0);               // removes the newest
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, '1);            // older one shows again
    queue_req(REQ_DEL, '1, 32'd0, 64'd0);
    queue_req(REQ_LOOKUP, '1, '1, '1);                  // falls back again
    queue_req(REQ_DEL, '1, 32'd0, 64'd0);               // already gone
    queue_req(REQ_UNUSED, '1, '1, '1);                  // ignored
    queue_req(REQ_DEL, 64'd0, 32'd0, 64'd0);
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, 64'd0);         // id 0, nothing at all
    queue_req(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 64'd0);
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(REQ_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555, 64'd0);
    queue_req(REQ_LOOKUP, 64'd0, 32'd0, 64'h5555_5555_5555_5555);

    // Random phases: length, drop mode, sender idle %, sink stall %, count, add %, delete %.
    run_phase(7'd8,   1'b0, 0,  0,  300, 45, 20, 1'b1);  // fills the table, long hold-off
    run_phase(7'd8,   1'b1, 61, 0,  200, 30, 30, 1'b0);  // same length keeps the table
    run_phase(7'd0,   1'b0, 0,  61, 300, 35, 25, 1'b0);  // every packet maps to id 0
    run_phase(7'd127, 1'b0, 37, 37, 300, 40, 25, 1'b0);  // length past 64 acts as 64
    run_phase(7'd1,   1'b0, 0,  0,  250, 35, 25, 1'b0);
    run_phase(7'd33,  1'b0, 61, 0,  250, 40, 20, 1'b0);
    run_phase(7'd63,  1'b0, 0,  61, 250, 35, 25, 1'b0);
    run_phase(7'd16,  1'b1, 37, 37, 200, 35, 25, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) n_errors++;

    $display("Checked %0d responses over %0d register settings:", n_checked, n_settings);
    $display("  %0d adds, %0d deletes, %0d lookups.", n_adds, n_dels, n_lookups);
    $display("Seen: %0d full-table adds, %0d missed deletes, %0d fallbacks,",
             n_full, n_missed_dels, n_fallbacks);
    $display("  %0d empty lookups, %0d drops; %0d errors.", n_empty, n_drops, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== locator_lookup_table_core.f =====
rtl/core/llt_pkg.sv
rtl/core/llt_ctrl.sv
rtl/core/llt_dp.sv
rtl/core/locator_lookup_table_core.sv
rtl/core/llt_checker.sv
tb/sv/tb_locator_lookup_table_core.sv
